/* sv/cmc_pkg.sv */
package cmc_pkg;

   // colour model codes
   localparam logic [1:0] MODEL_CMYK = 2'd0;
   localparam logic [1:0] MODEL_RGB  = 2'd1;
   localparam logic [1:0] MODEL_HSL  = 2'd2;
   localparam logic [1:0] MODEL_HSV  = 2'd3;

   // hue sextant codes
   localparam logic [2:0] SEC_0 = 3'd0;
   localparam logic [2:0] SEC_1 = 3'd1;
   localparam logic [2:0] SEC_2 = 3'd2;
   localparam logic [2:0] SEC_3 = 3'd3;
   localparam logic [2:0] SEC_4 = 3'd4;
   localparam logic [2:0] SEC_5 = 3'd5;

   // default widths
   localparam int COMP_BITS_DEF     = 12;
   localparam int HUE_FRAC_BITS_DEF = 4;

endpackage

/* sv/cmc_div.sv */
module cmc_div
   import cmc_pkg::*;
#(
   parameter int NW = 25,
   parameter int DW = 12,
   parameter int QW = 12
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   logic [NW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];

   // first stage adds half the divisor for round to nearest
   always_ff @(posedge clock) begin
      rem_ff[0] <= num + NW'(den >> 1);
      den_ff[0] <= den;
      quo_ff[0] <= '0;
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [NW:0]   trial_in;
      logic [QW-1:0] bit_in;
      always_comb begin
         trial_in = {1'b0, rem_ff[k-1]} - ((NW+1)'(den_ff[k-1]) << (QW - k));
         bit_in   = quo_ff[k-1];
         bit_in[QW-k] = ~trial_in[NW];
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= trial_in[NW] ? rem_ff[k-1] : trial_in[NW-1:0];
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= bit_in;
      end
   end

   // a zero divisor gives zero
   assign quo = (den_ff[QW] == '0) ? '0 : quo_ff[QW];

endmodule

/* sv/color_model_converter.sv */
// channel   ports                                        direction
// request   start, busy, req_type, req_comp_a..d,        in  (start/busy)
//           req_alpha_in
// response  rsp_valid, rsp_out_a..d, rsp_alpha_out,      out (strobe, no stall)
//           rsp_status
//
// one colour enters every clock while busy is low; each passes through the input
// register, the numbered stages, the pipelined restoring dividers that produce
// one quotient bit per stage, and the output register
// reset is synchronous and clears only the valid bits; busy is high in reset
// the receiver cannot stall, so every beat flows straight through
module color_model_converter
   import cmc_pkg::*;
#(
   parameter int COMP_BITS     = COMP_BITS_DEF,
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
   localparam int W    = COMP_BITS,
   localparam int H60  = 60 << HUE_FRAC_BITS,
   localparam int H360 = 360 << HUE_FRAC_BITS,
   localparam int HW   = $clog2(H360),
   localparam int IW   = (W + 1 > HW) ? W + 1 : HW,
   localparam int OW   = (W > HW) ? W : HW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [3:0]    req_type,
   input  logic [IW-1:0] req_comp_a,
   input  logic [IW-1:0] req_comp_b,
   input  logic [IW-1:0] req_comp_c,
   input  logic [IW-1:0] req_comp_d,
   input  logic [W-1:0]  req_alpha_in,
   output logic          rsp_valid,
   output logic [OW-1:0] rsp_out_a,
   output logic [W-1:0]  rsp_out_b,
   output logic [W-1:0]  rsp_out_c,
   output logic [W-1:0]  rsp_out_d,
   output logic [W-1:0]  rsp_alpha_out,
   output logic          rsp_status
);

   localparam int CMAX_I = (1 << W) - 1;
   localparam logic [W-1:0] CMAX = '1;
   localparam int H6W = $clog2(H60 + 1);
   localparam int QW  = (W > H6W) ? W : H6W;
   localparam int NW  = W + QW + 1;
   localparam int XW  = W + H6W + 1;
   localparam int VW  = XW - HUE_FRAC_BITS;
   localparam int RW  = VW - 5;
   localparam longint RECIP = (64'd1 << VW) / 60;
   localparam int SW  = ((HW > QW) ? HW : QW) + 2;

   typedef struct packed {
      logic [1:0]    src;
      logic [1:0]    tgt;
      logic          ok;
      logic [OW-1:0] a;
      logic [W-1:0]  b;
      logic [W-1:0]  c;
      logic [W-1:0]  d;
      logic [W-1:0]  alpha;
   } carry_type;

   typedef struct packed {
      logic [W-1:0]  r;
      logic [W-1:0]  g;
      logic [W-1:0]  b;
      logic [W-1:0]  mx;
      logic [W-1:0]  lval;
      logic [HW-1:0] base;
      logic          neg;
      logic          mx_zero;
      logic          delta_zero;
   } tail_type;

   typedef struct packed {
      carry_type cy;
      tail_type  tl;
   } side_type;

   // divide by the full-scale value, rounded to nearest
   function automatic logic [W-1:0] div_cmax(input logic [2*W-1:0] x);
      logic [2*W:0] y;
      logic [W:0]   q0;
      logic [W+1:0] r0;
      logic [W+1:0] q;
      y  = {1'b0, x} + (2*W+1)'(CMAX >> 1);
      q0 = y[2*W:W];
      r0 = {1'b0, q0} + {2'b00, y[W-1:0]};
      q  = {1'b0, q0} + (W+2)'(r0 >= (W+2)'(CMAX_I)) + (W+2)'(r0 >= (W+2)'(2 * CMAX_I));
      return q[W-1:0];
   endfunction

   // halve with rounding and clamp to full scale
   function automatic logic [W-1:0] halve_clamp(input logic signed [W+2:0] v);
      logic [W+2:0] h;
      h = (W+3)'($unsigned(v) + (W+3)'(1)) >> 1;
      if (v < 0) begin
         return '0;
      end else if (h > (W+3)'(CMAX_I)) begin
         return CMAX;
      end
      return h[W-1:0];
   endfunction

   assign busy = reset;

   // input register
   logic            s0_vld_ff;
   logic [3:0]      s0_type_ff;
   logic [IW-1:0]   s0_a_ff, s0_b_ff, s0_c_ff, s0_d_ff;
   logic [W-1:0]    s0_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start;
      end
      s0_type_ff  <= req_type;
      s0_a_ff     <= req_comp_a;
      s0_b_ff     <= req_comp_b;
      s0_c_ff     <= req_comp_c;
      s0_d_ff     <= req_comp_d;
      s0_alpha_ff <= req_alpha_in;
   end

   // stage 1: range check, products, hue sextant position
   carry_type         s1_cy_in;
   logic [W-1:0]      s1_opa_in [3];
   logic [W-1:0]      s1_opb_in [3];
   logic signed [W+1:0] s1_t2_in;
   logic [W+1:0]      s1_tabs_in;
   logic [W-1:0]      s1_span_in;
   logic [HW-1:0]     s1_hue_in;
   logic [2:0]        s1_sec_in;
   logic [HW-1:0]     s1_hp_in;
   logic [H6W-1:0]    s1_t_in;
   logic              a_cmp, b_cmp, c_cmp, d_cmp, h_cmp;

   always_comb begin
      a_cmp = s0_a_ff <= IW'(CMAX_I);
      b_cmp = s0_b_ff <= IW'(CMAX_I);
      c_cmp = s0_c_ff <= IW'(CMAX_I);
      d_cmp = s0_d_ff <= IW'(CMAX_I);
      h_cmp = s0_a_ff < IW'(H360);
      s1_cy_in.src   = s0_type_ff[3:2];
      s1_cy_in.tgt   = s0_type_ff[1:0];
      s1_cy_in.a     = s0_a_ff[OW-1:0];
      s1_cy_in.b     = s0_b_ff[W-1:0];
      s1_cy_in.c     = s0_c_ff[W-1:0];
      s1_cy_in.d     = (s0_type_ff[3:2] == MODEL_CMYK) ? s0_d_ff[W-1:0] : '0;
      s1_cy_in.alpha = s0_alpha_ff;
      unique case (s0_type_ff[3:2])
         MODEL_CMYK: s1_cy_in.ok = a_cmp && b_cmp && c_cmp && d_cmp;
         MODEL_RGB:  s1_cy_in.ok = a_cmp && b_cmp && c_cmp;
         default:    s1_cy_in.ok = h_cmp && b_cmp && c_cmp;
      endcase

      // lightness span for hsl chroma
      s1_t2_in   = $signed({1'b0, s0_c_ff[W-1:0], 1'b0}) - $signed({2'b00, CMAX});
      s1_tabs_in = (s1_t2_in < 0) ? $unsigned(-s1_t2_in) : $unsigned(s1_t2_in);
      s1_span_in = CMAX - s1_tabs_in[W-1:0];

      s1_opa_in[0] = CMAX - s0_d_ff[W-1:0];
      s1_opb_in[0] = CMAX - s0_a_ff[W-1:0];
      s1_opa_in[1] = CMAX - s0_d_ff[W-1:0];
      s1_opb_in[1] = CMAX - s0_b_ff[W-1:0];
      s1_opa_in[2] = CMAX - s0_d_ff[W-1:0];
      s1_opb_in[2] = CMAX - s0_c_ff[W-1:0];
      if (s0_type_ff[3:2] == MODEL_HSL) begin
         s1_opa_in[0] = s0_b_ff[W-1:0];
         s1_opb_in[0] = s1_span_in;
      end else if (s0_type_ff[3:2] == MODEL_HSV) begin
         s1_opa_in[0] = s0_c_ff[W-1:0];
         s1_opb_in[0] = s0_b_ff[W-1:0];
      end

      // sextant and distance from the centre of its sextant pair
      s1_hue_in = s0_a_ff[HW-1:0];
      priority if (s1_hue_in < HW'(H60))     s1_sec_in = SEC_0;
      else if (s1_hue_in < HW'(2 * H60))     s1_sec_in = SEC_1;
      else if (s1_hue_in < HW'(3 * H60))     s1_sec_in = SEC_2;
      else if (s1_hue_in < HW'(4 * H60))     s1_sec_in = SEC_3;
      else if (s1_hue_in < HW'(5 * H60))     s1_sec_in = SEC_4;
      else                                   s1_sec_in = SEC_5;
      unique case (s1_sec_in[2:1])
         2'd0:    s1_hp_in = s1_hue_in;
         2'd1:    s1_hp_in = s1_hue_in - HW'(2 * H60);
         default: s1_hp_in = s1_hue_in - HW'(4 * H60);
      endcase
      if (s1_hp_in > HW'(H60)) begin
         s1_t_in = H6W'(s1_hp_in - HW'(H60));
      end else begin
         s1_t_in = H6W'(HW'(H60) - s1_hp_in);
      end
   end

   logic            s1_vld_ff;
   carry_type       s1_cy_ff;
   logic [2*W-1:0]  s1_p_ff [3];
   logic [H6W-1:0]  s1_w60_ff;
   logic [2:0]      s1_sec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_cy_ff  <= s1_cy_in;
      s1_w60_ff <= H6W'(H60) - s1_t_in;
      s1_sec_ff <= s1_sec_in;
      for (int i = 0; i < 3; i++) begin
         s1_p_ff[i] <= (2*W)'(s1_opa_in[i]) * (2*W)'(s1_opb_in[i]);
      end
   end

   // stage 2: divide by full scale, chroma and offset
   logic [W-1:0]        s2_q_in [3];
   logic [W-1:0]        s2_rgb_in [3];
   logic signed [W+2:0] s2_m2_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_q_in[i] = div_cmax(s1_p_ff[i]);
      end
      if (s1_cy_ff.src == MODEL_RGB) begin
         s2_rgb_in[0] = s1_cy_ff.a[W-1:0];
         s2_rgb_in[1] = s1_cy_ff.b;
         s2_rgb_in[2] = s1_cy_ff.c;
      end else begin
         s2_rgb_in = s2_q_in;
      end
      if (s1_cy_ff.src == MODEL_HSL) begin
         s2_m2_in = $signed({2'b00, s1_cy_ff.c, 1'b0}) - $signed({3'b000, s2_q_in[0]});
      end else begin
         s2_m2_in = $signed({2'b00, s1_cy_ff.c, 1'b0}) - $signed({2'b00, s2_q_in[0], 1'b0});
      end
   end

   logic                s2_vld_ff;
   carry_type           s2_cy_ff;
   logic [W-1:0]        s2_rgb_ff [3];
   logic [W-1:0]        s2_ch_ff;
   logic signed [W+2:0] s2_m2_ff;
   logic [H6W-1:0]      s2_w60_ff;
   logic [2:0]          s2_sec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_cy_ff  <= s1_cy_ff;
      s2_rgb_ff <= s2_rgb_in;
      s2_ch_ff  <= s2_q_in[0];
      s2_m2_ff  <= s2_m2_in;
      s2_w60_ff <= s1_w60_ff;
      s2_sec_ff <= s1_sec_ff;
   end

   // stage 3: chroma times distance weight
   logic                s3_vld_ff;
   carry_type           s3_cy_ff;
   logic [W-1:0]        s3_rgb_ff [3];
   logic [W-1:0]        s3_ch_ff;
   logic signed [W+2:0] s3_m2_ff;
   logic [2:0]          s3_sec_ff;
   logic [XW-2:0]       s3_xp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_cy_ff  <= s2_cy_ff;
      s3_rgb_ff <= s2_rgb_ff;
      s3_ch_ff  <= s2_ch_ff;
      s3_m2_ff  <= s2_m2_ff;
      s3_sec_ff <= s2_sec_ff;
      s3_xp_ff  <= (XW-1)'(s2_ch_ff) * (XW-1)'(s2_w60_ff);
   end

   // stage 4: round away the fraction bits, estimate quotient by sixty
   logic [XW-1:0]    s4_sum_in;
   logic [VW-1:0]    s4_v_in;
   logic [VW+RW-1:0] s4_prod_in;

   always_comb begin
      s4_sum_in  = {1'b0, s3_xp_ff} + XW'(H60 / 2);
      s4_v_in    = s4_sum_in[XW-1:HUE_FRAC_BITS];
      s4_prod_in = (VW+RW)'(s4_v_in) * (VW+RW)'(RECIP);
   end

   logic                s4_vld_ff;
   carry_type           s4_cy_ff;
   logic [W-1:0]        s4_rgb_ff [3];
   logic [W-1:0]        s4_ch_ff;
   logic signed [W+2:0] s4_m2_ff;
   logic [2:0]          s4_sec_ff;
   logic [VW-1:0]       s4_v_ff;
   logic [W-1:0]        s4_q0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_cy_ff  <= s3_cy_ff;
      s4_rgb_ff <= s3_rgb_ff;
      s4_ch_ff  <= s3_ch_ff;
      s4_m2_ff  <= s3_m2_ff;
      s4_sec_ff <= s3_sec_ff;
      s4_v_ff   <= s4_v_in;
      s4_q0_ff  <= s4_prod_in[VW+W-1:VW];
   end

   // stage 5: correct the estimate, place channels by sextant
   logic [VW-1:0]       s5_r_in;
   logic [W-1:0]        s5_x_in;
   logic signed [W+2:0] s5_hi_in, s5_mid_in, s5_lo_in;
   logic signed [W+2:0] s5_v_in [3];
   logic [W-1:0]        s5_rgb_in [3];

   always_comb begin
      s5_r_in   = s4_v_ff - VW'(s4_q0_ff) * VW'(60);
      s5_x_in   = s4_q0_ff + W'(s5_r_in >= VW'(60));
      s5_lo_in  = s4_m2_ff;
      s5_hi_in  = s4_m2_ff + $signed({2'b00, s4_ch_ff, 1'b0});
      s5_mid_in = s4_m2_ff + $signed({2'b00, s5_x_in, 1'b0});
      unique case (s4_sec_ff)
         SEC_0:   s5_v_in = '{s5_hi_in,  s5_mid_in, s5_lo_in};
         SEC_1:   s5_v_in = '{s5_mid_in, s5_hi_in,  s5_lo_in};
         SEC_2:   s5_v_in = '{s5_lo_in,  s5_hi_in,  s5_mid_in};
         SEC_3:   s5_v_in = '{s5_lo_in,  s5_mid_in, s5_hi_in};
         SEC_4:   s5_v_in = '{s5_mid_in, s5_lo_in,  s5_hi_in};
         default: s5_v_in = '{s5_hi_in,  s5_lo_in,  s5_mid_in};
      endcase
      if (s4_cy_ff.src == MODEL_HSL || s4_cy_ff.src == MODEL_HSV) begin
         for (int i = 0; i < 3; i++) begin
            s5_rgb_in[i] = halve_clamp(s5_v_in[i]);
         end
      end else begin
         s5_rgb_in = s4_rgb_ff;
      end
   end

   logic         s5_vld_ff;
   carry_type    s5_cy_ff;
   logic [W-1:0] s5_rgb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      s5_cy_ff  <= s4_cy_ff;
      s5_rgb_ff <= s5_rgb_in;
   end

   // stage 6: max, min, hue sector and divider operands
   logic [W-1:0]      mx_in, mn_in, delta_in;
   logic [W:0]        sum_in;
   logic [W:0]        den_l_in;
   logic signed [W:0] hnum_in;
   logic [W:0]        habs_in;
   logic [W-1:0]      diff_in [3];
   logic [NW-1:0]     dnum_in [3];
   logic [W-1:0]      dden_in [3];
   tail_type          tl_in;

   always_comb begin
      mx_in = s5_rgb_ff[0];
      mn_in = s5_rgb_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (s5_rgb_ff[i] > mx_in) mx_in = s5_rgb_ff[i];
         if (s5_rgb_ff[i] < mn_in) mn_in = s5_rgb_ff[i];
      end
      delta_in = mx_in - mn_in;
      sum_in   = {1'b0, mx_in} + {1'b0, mn_in};
      den_l_in = (sum_in <= (W+1)'(CMAX_I)) ? sum_in : (W+1)'(2 * CMAX_I) - sum_in;

      // red wins ties over green, green over blue
      priority if (mx_in == s5_rgb_ff[0]) begin
         hnum_in    = $signed({1'b0, s5_rgb_ff[1]}) - $signed({1'b0, s5_rgb_ff[2]});
         tl_in.base = '0;
      end else if (mx_in == s5_rgb_ff[1]) begin
         hnum_in    = $signed({1'b0, s5_rgb_ff[2]}) - $signed({1'b0, s5_rgb_ff[0]});
         tl_in.base = HW'(2 * H60);
      end else begin
         hnum_in    = $signed({1'b0, s5_rgb_ff[0]}) - $signed({1'b0, s5_rgb_ff[1]});
         tl_in.base = HW'(4 * H60);
      end
      habs_in          = (hnum_in < 0) ? $unsigned(-hnum_in) : $unsigned(hnum_in);
      tl_in.neg        = hnum_in < 0;
      tl_in.r          = s5_rgb_ff[0];
      tl_in.g          = s5_rgb_ff[1];
      tl_in.b          = s5_rgb_ff[2];
      tl_in.mx         = mx_in;
      tl_in.lval       = W'((sum_in + (W+1)'(1)) >> 1);
      tl_in.mx_zero    = mx_in == '0;
      tl_in.delta_zero = delta_in == '0;

      for (int i = 0; i < 3; i++) begin
         diff_in[i] = mx_in - s5_rgb_ff[i];
         dnum_in[i] = (NW'(diff_in[i]) << W) - NW'(diff_in[i]);
         dden_in[i] = mx_in;
      end
      if (s5_cy_ff.tgt != MODEL_CMYK) begin
         dnum_in[0] = NW'(habs_in[W-1:0]) * NW'(H60);
         dden_in[0] = delta_in;
         dnum_in[1] = (NW'(delta_in) << W) - NW'(delta_in);
         dden_in[1] = (s5_cy_ff.tgt == MODEL_HSL) ? den_l_in[W-1:0] : mx_in;
      end
   end

   logic          s6_vld_ff;
   side_type      s6_side_ff;
   logic [NW-1:0] s6_num_ff [3];
   logic [W-1:0]  s6_den_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      s6_side_ff.cy <= s5_cy_ff;
      s6_side_ff.tl <= tl_in;
      s6_num_ff     <= dnum_in;
      s6_den_ff     <= dden_in;
   end

   // three pipelined dividers
   logic [QW-1:0] quo [3];

   for (genvar i = 0; i < 3; i++) begin : g_div
      cmc_div #(
         .NW (NW),
         .DW (W),
         .QW (QW)
      ) u_div (
         .clock (clock),
         .num   (s6_num_ff[i]),
         .den   (s6_den_ff[i]),
         .quo   (quo[i])
      );
   end

   // side data and valid bits follow the divider depth
   logic     dl_vld_ff  [QW+1];
   side_type dl_side_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            dl_vld_ff[k] <= 1'b0;
         end
      end else begin
         dl_vld_ff[0] <= s6_vld_ff;
         for (int k = 1; k <= QW; k++) begin
            dl_vld_ff[k] <= dl_vld_ff[k-1];
         end
      end
      dl_side_ff[0] <= s6_side_ff;
      for (int k = 1; k <= QW; k++) begin
         dl_side_ff[k] <= dl_side_ff[k-1];
      end
   end

   // result assembly
   side_type             sd;
   logic [W-1:0]         qc_in [3];
   logic signed [SW-1:0] hs_in;
   logic [HW-1:0]        hue_in;
   logic [OW-1:0]        ra_in;
   logic [W-1:0]         rb_in, rc_in, rd_in;

   always_comb begin
      sd = dl_side_ff[QW];
      for (int i = 0; i < 3; i++) begin
         qc_in[i] = (quo[i] > QW'(CMAX_I)) ? CMAX : quo[i][W-1:0];
      end
      hs_in = sd.tl.neg ? $signed(SW'(sd.tl.base)) - $signed(SW'(quo[0]))
                        : $signed(SW'(sd.tl.base)) + $signed(SW'(quo[0]));
      if (hs_in < 0) begin
         hs_in = hs_in + SW'(H360);
      end
      if (hs_in >= $signed(SW'(H360))) begin
         hs_in = hs_in - SW'(H360);
      end
      hue_in = sd.tl.delta_zero ? '0 : hs_in[HW-1:0];

      ra_in = '0;
      rb_in = '0;
      rc_in = '0;
      rd_in = '0;
      if (!sd.cy.ok) begin
         ra_in = '0;
      end else if (sd.cy.src == sd.cy.tgt) begin
         ra_in = sd.cy.a;
         rb_in = sd.cy.b;
         rc_in = sd.cy.c;
         rd_in = sd.cy.d;
      end else begin
         unique case (sd.cy.tgt)
            MODEL_CMYK: begin
               if (sd.tl.mx_zero) begin
                  rd_in = CMAX;
               end else begin
                  ra_in = OW'(qc_in[0]);
                  rb_in = qc_in[1];
                  rc_in = qc_in[2];
                  rd_in = CMAX - sd.tl.mx;
               end
            end
            MODEL_RGB: begin
               ra_in = OW'(sd.tl.r);
               rb_in = sd.tl.g;
               rc_in = sd.tl.b;
            end
            MODEL_HSL: begin
               ra_in = OW'(hue_in);
               rb_in = sd.tl.delta_zero ? '0 : qc_in[1];
               rc_in = sd.tl.lval;
            end
            default: begin
               ra_in = OW'(hue_in);
               rb_in = sd.tl.delta_zero ? '0 : qc_in[1];
               rc_in = sd.tl.mx;
            end
         endcase
      end
   end

   // output register
   logic          rsp_valid_ff;
   logic [OW-1:0] rsp_a_ff;
   logic [W-1:0]  rsp_b_ff, rsp_c_ff, rsp_d_ff, rsp_alpha_ff;
   logic          rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dl_vld_ff[QW];
      end
      rsp_a_ff      <= ra_in;
      rsp_b_ff      <= rb_in;
      rsp_c_ff      <= rc_in;
      rsp_d_ff      <= rd_in;
      rsp_alpha_ff  <= sd.cy.alpha;
      rsp_status_ff <= ~sd.cy.ok;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_a     = rsp_a_ff;
   assign rsp_out_b     = rsp_b_ff;
   assign rsp_out_c     = rsp_c_ff;
   assign rsp_out_d     = rsp_d_ff;
   assign rsp_alpha_out = rsp_alpha_ff;
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTHESIS
   // nothing comes out right after reset
   a_quiet_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // a rejected colour carries zero components
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_out_a == '0 && rsp_out_b == '0 && rsp_out_c == '0 && rsp_out_d == '0))
      else $error("rejected beat with non-zero components");

   // the first field never exceeds a full hue turn
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_a < OW'(H360)))
      else $error("first component out of range");
`endif

endmodule
